/* hdl/rs485n_pkg.sv */
// ----------------------------------------------------------------------------
// rs485n_pkg
// Shared constants, types and helpers for the register node with encoder.
// ----------------------------------------------------------------------------
package rs485n_pkg;

  localparam int PACKET_LEN        = 5;
  localparam int QUEUE_DEPTH_DFLT  = 4;

  localparam int BYTE_CNT_W = $clog2(PACKET_LEN);
  localparam int PKT_IDX_W  = $clog2(PACKET_LEN - 1);

  localparam logic [7:0] MASTER_ADDR   = 8'd1;
  localparam logic [7:0] CMD_READ      = 8'd10;
  localparam logic [7:0] CMD_WRITE     = 8'd20;
  localparam logic [7:0] CMD_ADDR      = 8'd30;
  localparam logic [7:0] CODE_REGS     = 8'd50;
  localparam logic [7:0] CODE_ACK      = 8'd60;
  localparam logic [7:0] ADDR_RESET    = 8'd50;
  localparam logic [7:0] TIMEOUT_RESET = 8'd32;
  localparam logic [7:0] BYTE_MAX      = 8'd255;

  // Item kinds on the command input.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // One finished item: the reply (if any) and the register values after it.
  typedef struct packed {
    logic       send;
    logic [7:0] code;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [7:0] check;
    logic [7:0] level;
    logic [7:0] switch_v;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [7:0] sum4(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3);
    return b0 + b1 + b2 + b3;
  endfunction

endpackage

/* hdl/rs485n_front.sv */
// ----------------------------------------------------------------------------
// rs485n_front
// Accepts words, gathers packets, samples the encoder and button, runs
// commands and hands a finished job to the queue.
// ----------------------------------------------------------------------------
module rs485n_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [7:0]          rx_byte,
  input  logic [1:0]          encoder_pins,
  input  logic                button_pin,
  input  rs485n_pkg::q_status_t q_stat,
  output logic                push,
  output rs485n_pkg::job_t    job
);

  localparam int BW = rs485n_pkg::BYTE_CNT_W;
  localparam int PW = rs485n_pkg::PKT_IDX_W;

  logic [7:0]    timeout_reg;
  logic [7:0]    node_address, node_address_next;
  logic [7:0]    level_reg, level_next;
  logic [7:0]    switch_reg, switch_next;
  logic [1:0]    prev_phases, prev_phases_next;
  logic          prev_button, prev_button_next;
  logic [BW-1:0] byte_count, byte_count_next;
  logic [7:0]    timeout_count, timeout_count_next;
  logic [7:0]    packet_bytes [rs485n_pkg::PACKET_LEN-1];
  logic          pkt_we;
  logic          accept;
  logic          up, down;
  logic [7:0]    to_sat;
  logic [7:0]    pkt_sum;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;

  assign pkt_sum = rs485n_pkg::sum4(packet_bytes[0], packet_bytes[1],
                                    packet_bytes[2], packet_bytes[3]);
  assign to_sat  = (timeout_count != rs485n_pkg::BYTE_MAX) ? timeout_count + 8'd1
                                                           : timeout_count;

  // Quadrature decode: one legal step of the Gray sequence moves the level.
  always_comb begin
    up   = 1'b0;
    down = 1'b0;
    unique case (prev_phases)
      2'd3: begin up = (encoder_pins == 2'd1); down = (encoder_pins == 2'd2); end
      2'd2: begin up = (encoder_pins == 2'd3); down = (encoder_pins == 2'd0); end
      2'd1: begin up = (encoder_pins == 2'd0); down = (encoder_pins == 2'd3); end
      default: begin up = (encoder_pins == 2'd2); down = (encoder_pins == 2'd1); end
    endcase
  end

  always_comb begin
    node_address_next  = node_address;
    level_next         = level_reg;
    switch_next        = switch_reg;
    prev_phases_next   = prev_phases;
    prev_button_next   = prev_button;
    byte_count_next    = byte_count;
    timeout_count_next = timeout_count;
    pkt_we             = 1'b0;
    job                = '0;

    if (command == rs485n_pkg::KIND_BYTE) begin
      if (byte_count < BW'(rs485n_pkg::PACKET_LEN - 1)) begin
        if (byte_count == '0) begin
          timeout_count_next = '0;
        end
        pkt_we          = 1'b1;
        byte_count_next = byte_count + BW'(1);
      end else begin
        byte_count_next    = '0;
        timeout_count_next = '0;
        if (pkt_sum == rx_byte && packet_bytes[0] == node_address) begin
          priority if (packet_bytes[1] == rs485n_pkg::CMD_READ) begin
            job.send  = 1'b1;
            job.code  = rs485n_pkg::CODE_REGS;
            job.data0 = level_reg;
            job.data1 = switch_reg;
          end else if (packet_bytes[1] == rs485n_pkg::CMD_WRITE) begin
            level_next  = packet_bytes[2];
            switch_next = packet_bytes[3];
            job.send    = 1'b1;
            job.code    = rs485n_pkg::CODE_ACK;
            job.data0   = node_address;
          end else if (packet_bytes[1] == rs485n_pkg::CMD_ADDR) begin
            node_address_next = packet_bytes[2];
            job.send          = 1'b1;
            job.code          = rs485n_pkg::CODE_ACK;
            job.data0         = packet_bytes[2];
          end else begin
            job.send = 1'b0;
          end
        end
      end
    end else if (byte_count != '0) begin
      // Partial packet pending: count towards the timeout, no sampling.
      if (to_sat >= timeout_reg) begin
        byte_count_next    = '0;
        timeout_count_next = '0;
      end else begin
        timeout_count_next = to_sat;
      end
    end else begin
      if (up && level_reg != rs485n_pkg::BYTE_MAX) begin
        level_next = level_reg + 8'd1;
      end else if (down && level_reg != 8'd0) begin
        level_next = level_reg - 8'd1;
      end
      if (prev_button && !button_pin) begin
        switch_next = (switch_reg == 8'd0) ? 8'd1 : 8'd0;
      end
      prev_phases_next = encoder_pins;
      prev_button_next = button_pin;
    end

    job.check    = rs485n_pkg::sum4(rs485n_pkg::MASTER_ADDR, job.code,
                                    job.data0, job.data1);
    job.level    = level_next;
    job.switch_v = switch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_reg   <= rs485n_pkg::TIMEOUT_RESET;
      node_address  <= rs485n_pkg::ADDR_RESET;
      level_reg     <= '0;
      switch_reg    <= '0;
      prev_phases   <= '0;
      prev_button   <= 1'b0;
      byte_count    <= '0;
      timeout_count <= '0;
    end else begin
      if (cfg_we) begin
        timeout_reg <= cfg_wdata;
      end
      if (accept) begin
        node_address  <= node_address_next;
        level_reg     <= level_next;
        switch_reg    <= switch_next;
        prev_phases   <= prev_phases_next;
        prev_button   <= prev_button_next;
        byte_count    <= byte_count_next;
        timeout_count <= timeout_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt_we) begin
      packet_bytes[byte_count[PW-1:0]] <= rx_byte;
    end
  end

endmodule

/* hdl/rs485n_queue.sv */
// ----------------------------------------------------------------------------
// rs485n_queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module rs485n_queue #(
  parameter int DEPTH = rs485n_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rs485n_pkg::job_t      push_job,
  input  logic                  pop,
  output rs485n_pkg::job_t      head,
  output rs485n_pkg::q_status_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rs485n_pkg::job_t entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign head          = entries[rd_ptr];
  assign q_stat.empty  = (count == '0);
  assign q_stat.full   = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* hdl/rs485n_back.sv */
// ----------------------------------------------------------------------------
// rs485n_back
// Turns the job at the head of the queue into one status word or a
// five-word reply on the output channel.
// ----------------------------------------------------------------------------
module rs485n_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rs485n_pkg::job_t      head,
  input  rs485n_pkg::q_status_t q_stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  has_tx_byte,
  output logic [7:0]            tx_byte,
  output logic                  last_of_reply,
  output logic [7:0]            level_value,
  output logic [7:0]            switch_value
);

  localparam int RW = $clog2(rs485n_pkg::PACKET_LEN);

  logic [RW-1:0] idx;
  logic [7:0]    reply_byte;

  always_comb begin
    unique case (idx)
      RW'(0):  reply_byte = rs485n_pkg::MASTER_ADDR;
      RW'(1):  reply_byte = head.code;
      RW'(2):  reply_byte = head.data0;
      RW'(3):  reply_byte = head.data1;
      default: reply_byte = head.check;
    endcase
  end

  assign out_valid     = !q_stat.empty;
  assign has_tx_byte   = head.send;
  assign tx_byte       = head.send ? reply_byte : 8'd0;
  assign last_of_reply = !head.send || (idx == RW'(rs485n_pkg::PACKET_LEN - 1));
  assign level_value   = head.level;
  assign switch_value  = head.switch_v;
  assign pop           = out_valid && out_ready && last_of_reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= last_of_reply ? '0 : idx + RW'(1);
    end
  end

endmodule

/* hdl/rs485_register_node_with_encoder.sv */
// ----------------------------------------------------------------------------
// rs485_register_node_with_encoder
// Bus slave node: packet receiver, encoder and button sampler, reply sender.
// ----------------------------------------------------------------------------
// The input channel carries one word per serial byte (command low) or timer
// tick (command high, with encoder and button samples). Each accepted word
// gives either one status word on the output channel or, for a packet that
// calls for an answer, a five-word reply with last_of_reply on the final one.
// Every output word carries the level and switch registers after its item.
// The front part works on a word in the cycle it is accepted; its job goes
// into a queue of QUEUE_DEPTH entries and reaches the output once it is at
// the head of that queue. The input takes one word per cycle while the
// queue has room; the back part sends one output word per cycle while
// out_ready is high, so a reply holds the output for its five words.
// When the receiver stalls, the queue fills and in_ready falls; nothing is
// lost. Reset clears the queue, empties any partial packet and sets the
// address to 50, the timeout to 32 ticks and both registers to zero.
// cfg_we writes the timeout register at once and should only be used idle.
// ----------------------------------------------------------------------------
module rs485_register_node_with_encoder #(
  parameter int QUEUE_DEPTH = rs485n_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] rx_byte,
  input  logic [1:0] encoder_pins,
  input  logic       button_pin,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       has_tx_byte,
  output logic [7:0] tx_byte,
  output logic       last_of_reply,
  output logic [7:0] level_value,
  output logic [7:0] switch_value
);

  rs485n_pkg::job_t      push_job;
  rs485n_pkg::job_t      head;
  rs485n_pkg::q_status_t q_stat;
  logic                  push;
  logic                  pop;

  rs485n_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .rx_byte      (rx_byte),
    .encoder_pins (encoder_pins),
    .button_pin   (button_pin),
    .q_stat       (q_stat),
    .push         (push),
    .job          (push_job)
  );

  rs485n_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  rs485n_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .has_tx_byte   (has_tx_byte),
    .tx_byte       (tx_byte),
    .last_of_reply (last_of_reply),
    .level_value   (level_value),
    .switch_value  (switch_value)
  );

  // A status word always closes its item.
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_tx_byte |-> last_of_reply)
    else $error("status word without last_of_reply");

  // A reply, once started, continues with the next word straight away.
  a_reply_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_reply |=> out_valid && has_tx_byte)
    else $error("reply broken off before its last word");

  // The front must not take a word when the queue has no room.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !in_ready)
    else $error("input accepted with the queue full");

  // Words reach the output only after something was queued.
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output word present straight after reset");

endmodule
